### src/arena_bump_allocator_lookback_defines.svh
// assertion macros for the arena allocator checker
`ifndef ARENA_BUMP_ALLOCATOR_LOOKBACK_DEFINES_SVH
`define ARENA_BUMP_ALLOCATOR_LOOKBACK_DEFINES_SVH

// clocked check, off while reset is asserted
`define ABA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ABA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/aba_pkg.sv
`timescale 1ns / 1ps

package aba_pkg;

    localparam int WORD_BYTES = 8;
    localparam int LOOKBACK   = 8;
    localparam int MAX_BLOCKS = 64;

    localparam int WB_LOG = $clog2(WORD_BYTES);
    localparam int REQ_W  = 20;
    localparam int SZ_W   = 21;
    localparam int BID_W  = 6;
    localparam int CNT_W  = $clog2(MAX_BLOCKS);
    localparam int USED_W = 32;
    localparam int BS_W   = 14;
    localparam int IDX_W  = (LOOKBACK > 1) ? $clog2(LOOKBACK) : 1;
    localparam int GUARD_MIN = 4;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_POOL_KIND    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GUARD_ON     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_WORD_ON = 2'd2;

    localparam logic [1:0] KIND_512  = 2'd0;
    localparam logic [1:0] KIND_4096 = 2'd1;
    localparam logic [1:0] KIND_8192 = 2'd2;

    localparam logic [BS_W-1:0] BS_512  = BS_W'(512);
    localparam logic [BS_W-1:0] BS_4096 = BS_W'(4096);
    localparam logic [BS_W-1:0] BS_8192 = BS_W'(8192);

    typedef struct packed {
        logic             valid;
        logic [BID_W-1:0] blk;
        logic [SZ_W-1:0]  cap;
        logic [SZ_W-1:0]  free;
    } cell_t;

    typedef struct packed {
        logic            restart;
        logic            shift;
        logic [SZ_W-1:0] restart_size;
        logic [SZ_W-1:0] foot;
    } cell_ctl_t;

    typedef struct packed {
        logic [SZ_W-1:0] foot;
        logic            head_on;
    } foot_t;

    localparam cell_t HEAD_RESET = '{valid: 1'b1, blk: '0,
                                     cap: SZ_W'(BS_512), free: SZ_W'(BS_512)};

    function automatic logic [BS_W-1:0] kind_size(input logic [1:0] k);
        logic [BS_W-1:0] s;
        case (k)
            KIND_4096: s = BS_4096;
            KIND_8192: s = BS_8192;
            default:   s = BS_512;
        endcase
        return s;
    endfunction

endpackage

### src/arena_bump_allocator_lookback.sv
// an accepted word is held in the input stage, then its result in the output register
// throughput: one word per cycle while the output is taken; set by the combinational
// compare and priority pick across the look-back cell chain
// reset: asynchronous, active low; cell 0 holds a 512-byte block, totals at zero
// a write of pool_kind restarts the arena with the new block size
`timescale 1ns / 1ps

module arena_bump_allocator_lookback
    import aba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [REQ_W-1:0]  request_bytes,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [BID_W-1:0]  block_id,
    output logic [SZ_W-1:0]   data_offset,
    output logic              opened_block,
    output logic [USED_W-1:0] used_total
);

    localparam logic [SZ_W-1:0] WB = SZ_W'(WORD_BYTES);

    logic [1:0]        pool_kind_reg;
    logic              guard_on_reg;
    logic              size_word_on_reg;
    logic [BS_W-1:0]   bs_reg;
    logic [BS_W-1:0]   bs_next;
    logic [CNT_W-1:0]  opened_reg;
    logic [CNT_W-1:0]  opened_next;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;

    logic              a_valid_reg;
    logic              a_valid_next;
    foot_t             a_foot_reg;
    foot_t             foot_in;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              ok_reg;
    logic [BID_W-1:0]  block_id_reg;
    logic [SZ_W-1:0]   data_offset_reg;
    logic              opened_blk_reg;
    logic [USED_W-1:0] used_total_reg;

    logic              cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic              restart;
    logic              accept;
    logic              a_fire;

    cell_ctl_t         ctl;
    cell_t             cells [LOOKBACK];
    cell_t             new_cell;
    logic [LOOKBACK-1:0] fit;
    logic [LOOKBACK-1:0] hit_oh;
    logic [IDX_W-1:0]  hit_idx;
    logic              hit_any;
    logic              found;
    cell_t             hit_cell;

    logic [SZ_W-1:0]   head;
    logic [BS_W-1:0]   bs_up;
    logic              exhaust;
    logic [SZ_W-1:0]   bs_mask;
    logic [SZ_W-1:0]   bsize;
    logic [USED_W:0]   used_sum;
    logic [USED_W-1:0] used_sat;
    logic              miss;
    logic              placed;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign restart = cfg_wr && (cfg_idx == REG_POOL_KIND);

    always_comb
    begin
        case (cfg_idx)
            REG_POOL_KIND:    prdata = DATA_W'(pool_kind_reg);
            REG_GUARD_ON:     prdata = DATA_W'(guard_on_reg);
            REG_SIZE_WORD_ON: prdata = DATA_W'(size_word_on_reg);
            default:          prdata = '0;
        endcase
    end

    aba_foot u_foot (
        .request_bytes (request_bytes),
        .guard_on      (guard_on_reg),
        .size_word_on  (size_word_on_reg),
        .foot          (foot_in)
    );

    assign in_stall = a_valid_reg && !a_fire;
    assign accept   = in_valid && !in_stall;
    assign a_fire   = a_valid_reg && (!out_valid_reg || !out_stall);

    // newest-first pick over the chain
    always_comb
    begin
        found   = 1'b0;
        hit_oh  = '0;
        hit_idx = '0;
        for (int i = 0; i < LOOKBACK; i++)
        begin
            if (fit[i] && !found)
            begin
                found     = 1'b1;
                hit_oh[i] = 1'b1;
                hit_idx   = IDX_W'(i);
            end
        end
        hit_any  = found;
        hit_cell = cells[hit_idx];
    end

    always_comb
    begin
        head = a_foot_reg.head_on ? WB : '0;
        miss = !hit_any;

        if ((int'(opened_reg) > 4) && (bs_reg < BS_4096))
            bs_up = BS_4096;
        else if ((int'(opened_reg) > 8) && (bs_reg < BS_8192))
            bs_up = BS_8192;
        else
            bs_up = bs_reg;

        exhaust = (int'(opened_reg) + 1) >= MAX_BLOCKS;
        placed  = !(miss && exhaust);

        bs_mask = SZ_W'(bs_up) - SZ_W'(1);
        bsize   = (a_foot_reg.foot + bs_mask) & ~bs_mask;

        new_cell.valid = 1'b1;
        new_cell.blk   = BID_W'(opened_reg + CNT_W'(1));
        new_cell.cap   = bsize;
        new_cell.free  = bsize - a_foot_reg.foot;

        used_sum = {1'b0, used_reg} + (USED_W + 1)'(a_foot_reg.foot);
        used_sat = used_sum[USED_W] ? '1 : used_sum[USED_W-1:0];

        ctl.restart      = restart;
        ctl.shift        = a_fire && miss && !exhaust;
        ctl.restart_size = SZ_W'(kind_size(pwdata[1:0]));
        ctl.foot         = a_foot_reg.foot;
    end

    genvar g;
    generate
        for (g = 0; g < LOOKBACK; g++)
        begin : g_cell
            aba_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .is_head (g == 0),
                .ctl     (ctl),
                .consume (a_fire && hit_oh[g]),
                .up      ((g == 0) ? new_cell : cells[(g == 0) ? 0 : g - 1]),
                .cur     (cells[g]),
                .fit     (fit[g])
            );
        end
    endgenerate

    always_comb
    begin
        bs_next     = bs_reg;
        opened_next = opened_reg;
        used_next   = used_reg;
        if (restart)
        begin
            bs_next     = kind_size(pwdata[1:0]);
            opened_next = '0;
            used_next   = '0;
        end
        else if (a_fire)
        begin
            if (miss)
                bs_next = bs_up;
            if (ctl.shift)
                opened_next = opened_reg + CNT_W'(1);
            if (placed)
                used_next = used_sat;
        end

        a_valid_next = a_valid_reg;
        if (accept)
            a_valid_next = 1'b1;
        else if (a_fire)
            a_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (a_fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_kind_reg    <= KIND_512;
            guard_on_reg     <= 1'b0;
            size_word_on_reg <= 1'b0;
            bs_reg           <= BS_512;
            opened_reg       <= '0;
            used_reg         <= '0;
            a_valid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_POOL_KIND:    pool_kind_reg    <= pwdata[1:0];
                    REG_GUARD_ON:     guard_on_reg     <= pwdata[0];
                    REG_SIZE_WORD_ON: size_word_on_reg <= pwdata[0];
                    default:          ;
                endcase
            end
            bs_reg        <= bs_next;
            opened_reg    <= opened_next;
            used_reg      <= used_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
            a_foot_reg <= foot_in;
        if (a_fire)
        begin
            ok_reg          <= placed;
            opened_blk_reg  <= miss && placed;
            used_total_reg  <= placed ? used_sat : used_reg;
            if (!placed)
            begin
                block_id_reg    <= '0;
                data_offset_reg <= '0;
            end
            else if (miss)
            begin
                block_id_reg    <= new_cell.blk;
                data_offset_reg <= head;
            end
            else
            begin
                block_id_reg    <= hit_cell.blk;
                data_offset_reg <= hit_cell.cap - hit_cell.free + head;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign block_id     = block_id_reg;
    assign data_offset  = data_offset_reg;
    assign opened_block = opened_blk_reg;
    assign used_total   = used_total_reg;

endmodule

### src/aba_foot.sv
`timescale 1ns / 1ps

module aba_foot
    import aba_pkg::*;
(
    input  logic [REQ_W-1:0] request_bytes,
    input  logic             guard_on,
    input  logic             size_word_on,
    output foot_t            foot
);

    localparam logic [SZ_W-1:0] WB     = SZ_W'(WORD_BYTES);
    localparam logic [SZ_W-1:0] WB_M1  = SZ_W'(WORD_BYTES - 1);
    localparam logic [SZ_W-1:0] GUARD  = SZ_W'(GUARD_MIN);

    logic [SZ_W-1:0] req_ext;
    logic [SZ_W-1:0] aligned;
    logic            slack;
    logic [SZ_W-1:0] guard_add;
    logic [SZ_W-1:0] head_add;

    always_comb
    begin
        req_ext   = SZ_W'(request_bytes);
        aligned   = (req_ext + WB_M1) & ~WB_M1;
        slack     = aligned > (req_ext + GUARD);
        guard_add = (guard_on && !slack) ? WB : '0;
        head_add  = size_word_on ? WB : '0;
        foot.foot    = aligned + guard_add + head_add;
        foot.head_on = size_word_on;
    end

endmodule

### src/aba_cell.sv
`timescale 1ns / 1ps

module aba_cell
    import aba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      is_head,
    input  cell_ctl_t ctl,
    input  logic      consume,
    input  cell_t     up,
    output cell_t     cur,
    output logic      fit
);

    cell_t cell_reg;
    cell_t cell_next;

    always_comb
    begin
        cell_next = cell_reg;
        if (ctl.restart)
        begin
            cell_next = '0;
            if (is_head)
            begin
                cell_next.valid = 1'b1;
                cell_next.cap   = ctl.restart_size;
                cell_next.free  = ctl.restart_size;
            end
        end
        else if (ctl.shift)
        begin
            cell_next = up;
        end
        else if (consume)
        begin
            cell_next.free = cell_reg.free - ctl.foot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= is_head ? HEAD_RESET : '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cur = cell_reg;
    assign fit = cell_reg.valid && (cell_reg.free >= ctl.foot);

endmodule

### src/aba_checker.sv
`timescale 1ns / 1ps
`include "arena_bump_allocator_lookback_defines.svh"

module aba_checker
    import aba_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic              ok,
    input logic [BID_W-1:0]  block_id,
    input logic [SZ_W-1:0]   data_offset,
    input logic              opened_block,
    input logic [USED_W-1:0] used_total
);

    // a held result word stays valid and keeps its used total and data offset
    `ABA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(used_total) && $stable(data_offset), "result word changed while stalled")

    // failure words carry no placement
    `ABA_ASSERT(a_fail_zero, out_valid && !ok |-> block_id == '0 && data_offset == '0 && !opened_block, "failed allocation carries placement")

    // a fresh block puts data at its start or after the size word
    `ABA_ASSERT(a_open_offset, out_valid && ok && opened_block |-> data_offset == '0 || data_offset == SZ_W'(WORD_BYTES), "new block offset wrong")

    // offsets stay on word boundaries
    `ABA_ASSERT(a_offset_aligned, out_valid && ok |-> data_offset[WB_LOG-1:0] == '0, "data offset not word aligned")

    // output valid is clear once reset has been seen
    `ABA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result shown in reset")

endmodule

bind arena_bump_allocator_lookback aba_checker u_aba_checker (.*);
